FILE: sv/dcr_pkg.sv
// Shared constants, types and the tanh lookup table for the damped comb resonator.
// Used by dcr_ctrl, dcr_datapath and damped_comb_resonator; depends on nothing.
package dcr_pkg;

	localparam int CHANNELS        = 2;
	localparam int BUF_DEPTH       = 32768;
	localparam int TANH_TABLE_SIZE = 256;
	localparam int CF_TERMS        = 24;
	localparam int SPAN_SHIFT      = 25;
	localparam int Q23_ONE         = 8388608;

	localparam int SMP_W      = 24;
	localparam int OUT_W      = 25;
	localparam int DLEN_W     = 15;
	localparam int COEF_W     = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam int CH_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int PTR_W     = $clog2(BUF_DEPTH);
	localparam int PTR_X_W   = PTR_W + 1;
	localparam int MEM_DEPTH = CHANNELS * BUF_DEPTH;
	localparam int ADDR_W    = $clog2(MEM_DEPTH);

	localparam int TAB_W     = 24;
	localparam int TI_W      = $clog2(TANH_TABLE_SIZE + 1);
	localparam int POS_W     = SPAN_SHIFT + TI_W;
	localparam int FRAC_LO_W = 12;
	localparam int FRAC_HI_W = SPAN_SHIFT - FRAC_LO_W;

	localparam int MUL_A_W = 26;
	localparam int MUL_B_W = 17;
	localparam int PROD_W  = MUL_A_W + MUL_B_W;
	localparam int ISUM_W  = PROD_W + FRAC_LO_W + 1;

	localparam logic [DLEN_W-1:0] DLEN_RESET = DLEN_W'(1200);
	localparam logic [COEF_W-1:0] DAMP_RESET = COEF_W'(21287);
	localparam logic [COEF_W-1:0] GAIN_RESET = COEF_W'(55706);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DELAY_LENGTH        = 2'd0,
		REG_DAMPING_COEFFICIENT = 2'd1,
		REG_FEEDBACK_GAIN       = 2'd2
	} cfg_reg_t;

	typedef enum logic [1:0] {
		OP_DIFF,
		OP_GAIN,
		OP_FRAC_HI,
		OP_FRAC_LO
	} mul_op_t;

	typedef struct packed {
		logic    load;
		logic    read;
		logic    mul_en;
		mul_op_t mul_op;
		logic    damp_upd;
		logic    tanh_prep;
		logic    interp;
		logic    commit;
	} dcr_cmd_t;

	typedef struct packed {
		logic ch_ok;
	} dcr_sts_t;

	typedef logic [TAB_W-1:0] tanh_tab_t [0:TANH_TABLE_SIZE];

	// restoring long division of two unsigned values, used only to build the table
	function automatic longint unsigned udiv64(input longint unsigned num,
			input longint unsigned den);
		longint unsigned q;
		longint unsigned r;
		int              b;
		q = '0;
		r = '0;
		for (b = 63; b >= 0; b--) begin
			r = {r[62:0], num[b]};
			if (r >= den) begin
				r = r - den;
				q[b] = 1'b1;
			end
		end
		return q;
	endfunction

	// tanh(x) for x in [0, 4] sampled at TANH_TABLE_SIZE+1 points, Q1.23, capped at 1.0
	function automatic tanh_tab_t build_tanh_tab();
		tanh_tab_t         tab;
		longint unsigned   xq;
		longint unsigned   x2;
		longint unsigned   t;
		longint unsigned   v;
		longint unsigned   span;
		int                i;
		int                k;
		span = longint'(TANH_TABLE_SIZE);
		for (i = 0; i <= TANH_TABLE_SIZE; i++) begin
			xq = udiv64(longint'(i) << 26, span);
			x2 = (xq * xq) >> 24;
			t = longint'(2 * CF_TERMS + 1) << 24;
			for (k = CF_TERMS - 1; k >= 0; k--) begin
				t = (longint'(2 * k + 1) << 24) + udiv64(x2 << 24, t);
			end
			v = (udiv64(xq << 24, t) + 1) >> 1;
			if (v > longint'(Q23_ONE)) begin
				v = longint'(Q23_ONE);
			end
			tab[i] = TAB_W'(v);
		end
		return tab;
	endfunction

	localparam tanh_tab_t TANH_TAB = build_tanh_tab();

endpackage

FILE: sv/dcr_ctrl.sv
// Sequencing state machine for the damped comb resonator.
// Drives the datapath commands and both handshakes; depends on dcr_pkg.
module dcr_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	output logic              out_valid,
	input  logic              out_stall,
	input  dcr_pkg::dcr_sts_t sts,
	output dcr_pkg::dcr_cmd_t cmd
);
	import dcr_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE,
		S_READ,
		S_MUL_DIFF,
		S_UPD_DAMP,
		S_MUL_GAIN,
		S_TANH,
		S_MUL_HI,
		S_MUL_LO,
		S_INTERP,
		S_WRITE
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   slot_free;

	assign slot_free = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd           = '0;
		cmd.mul_op    = OP_DIFF;
		cmd.load      = (state_q == S_IDLE) && in_valid;
		cmd.read      = (state_q == S_READ) && sts.ch_ok;
		cmd.damp_upd  = (state_q == S_UPD_DAMP);
		cmd.tanh_prep = (state_q == S_TANH);
		cmd.interp    = (state_q == S_INTERP);
		cmd.commit    = (state_q == S_WRITE) && slot_free;
		case (state_q)
			S_MUL_DIFF: begin
				cmd.mul_en = 1'b1;
				cmd.mul_op = OP_DIFF;
			end
			S_MUL_GAIN: begin
				cmd.mul_en = 1'b1;
				cmd.mul_op = OP_GAIN;
			end
			S_MUL_HI: begin
				cmd.mul_en = 1'b1;
				cmd.mul_op = OP_FRAC_HI;
			end
			S_MUL_LO: begin
				cmd.mul_en = 1'b1;
				cmd.mul_op = OP_FRAC_LO;
			end
			default: begin
				cmd.mul_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_READ;
					end
				end
				S_READ: begin
					// drop straight to the result for a channel that does not exist
					state_q <= sts.ch_ok ? S_MUL_DIFF : S_WRITE;
				end
				S_MUL_DIFF: state_q <= S_UPD_DAMP;
				S_UPD_DAMP: state_q <= S_MUL_GAIN;
				S_MUL_GAIN: state_q <= S_TANH;
				S_TANH:     state_q <= S_MUL_HI;
				S_MUL_HI:   state_q <= S_MUL_LO;
				S_MUL_LO:   state_q <= S_INTERP;
				S_INTERP:   state_q <= S_WRITE;
				S_WRITE: begin
					if (slot_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

FILE: sv/dcr_datapath.sv
// Datapath of the damped comb resonator: configuration registers, delay memory,
// per-channel pointers and damping state, shared multiplier and tanh interpolation.
// Depends on dcr_pkg; sequenced by dcr_ctrl.
module dcr_datapath (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  dcr_pkg::dcr_cmd_t                    cmd,
	output dcr_pkg::dcr_sts_t                    sts,
	input  logic                                 cfg_we,
	input  logic [dcr_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [dcr_pkg::CFG_DATA_W-1:0]       cfg_data,
	input  logic                                 channel,
	input  logic signed [dcr_pkg::SMP_W-1:0]     sample_in,
	output logic signed [dcr_pkg::OUT_W-1:0]     sample_out
);
	import dcr_pkg::*;

	localparam logic signed [PROD_W-1:0] PROD_HALF = PROD_W'(32768);
	localparam logic [ISUM_W-1:0]        ISUM_HALF = ISUM_W'(1) << (SPAN_SHIFT - 1);
	localparam logic [PTR_X_W-1:0]       DEPTH_X   = PTR_X_W'(BUF_DEPTH);

	function automatic logic signed [OUT_W-1:0] sat25(input logic signed [27:0] v);
		logic signed [27:0] hi;
		logic signed [27:0] lo;
		hi = 28'sd16777215;
		lo = -28'sd16777216;
		if (v > hi) begin
			return OUT_W'(hi);
		end else if (v < lo) begin
			return OUT_W'(lo);
		end
		return OUT_W'(v);
	endfunction

	// configuration
	logic [DLEN_W-1:0] dlen_q;
	logic [COEF_W-1:0] dcoef_q;
	logic [COEF_W-1:0] gain_q;

	// per-channel state
	logic [PTR_W-1:0]        wp_q [0:CHANNELS-1];
	logic                    wrapped_q [0:CHANNELS-1];
	logic signed [OUT_W-1:0] damp_q [0:CHANNELS-1];

	// delay memory
	logic signed [OUT_W-1:0] mem_q [0:MEM_DEPTH-1];
	logic signed [OUT_W-1:0] rdata_q;
	logic                    rdv_q;

	// request registers
	logic                    ch_q;
	logic                    ch_ok_q;
	logic signed [SMP_W-1:0] smp_q;
	logic signed [OUT_W-1:0] sample_out_q;

	// arithmetic registers
	logic signed [PROD_W-1:0] prod_q;
	logic signed [PROD_W-1:0] acc_q;
	logic                     neg_q;
	logic                     sat_q;
	logic [TAB_W-1:0]         lo_q;
	logic [TAB_W-1:0]         d_q;
	logic [SPAN_SHIFT-1:0]    frac_q;
	logic signed [25:0]       y_q;

	logic [CH_W-1:0]         ch_idx;
	logic [PTR_W-1:0]        wp_cur;
	logic signed [OUT_W-1:0] damp_cur;
	logic [PTR_W-1:0]        dly;
	logic [PTR_X_W-1:0]      rp_x;
	logic [PTR_W-1:0]        rp;
	logic [ADDR_W-1:0]       raddr;
	logic [ADDR_W-1:0]       waddr;
	logic signed [OUT_W-1:0] delayed;

	logic signed [MUL_A_W-1:0] mul_a;
	logic signed [MUL_B_W-1:0] mul_b;
	logic signed [PROD_W-1:0]  prod_sum;
	logic signed [PROD_W-1:0]  prod_rnd;
	logic signed [27:0]        damp_sum;
	logic signed [OUT_W-1:0]   damp_new;

	logic [PROD_W-1:0]     x_abs;
	logic [OUT_W-1:0]      ax;
	logic [POS_W-1:0]      pos;
	logic [TI_W-1:0]       idx;
	logic                  sat;
	logic [TI_W-1:0]       ti;
	logic [TAB_W-1:0]      t_lo;
	logic [TAB_W-1:0]      t_hi;

	logic [ISUM_W-1:0]     isum;
	logic [OUT_W-1:0]      ymag;
	logic signed [27:0]    w_sum;
	logic signed [OUT_W-1:0] w_val;

	assign ch_idx   = CH_W'(ch_q);
	assign wp_cur   = wp_q[ch_idx];
	assign damp_cur = damp_q[ch_idx];
	assign delayed  = rdv_q ? rdata_q : '0;
	assign sts.ch_ok = ch_ok_q;
	assign sample_out = sample_out_q;

	// read pointer: delay clamped to 1..BUF_DEPTH-1, behind the write position with wrap
	always_comb begin
		if (dlen_q == '0) begin
			dly = PTR_W'(1);
		end else if (32'(dlen_q) > 32'(BUF_DEPTH - 1)) begin
			dly = PTR_W'(BUF_DEPTH - 1);
		end else begin
			dly = PTR_W'(dlen_q);
		end
		if (wp_cur >= dly) begin
			rp_x = {1'b0, wp_cur} - {1'b0, dly};
		end else begin
			rp_x = {1'b0, wp_cur} + DEPTH_X - {1'b0, dly};
		end
		rp = rp_x[PTR_W-1:0];
	end

	assign raddr = ADDR_W'(ch_idx) * ADDR_W'(BUF_DEPTH) + ADDR_W'(rp);
	assign waddr = ADDR_W'(ch_idx) * ADDR_W'(BUF_DEPTH) + ADDR_W'(wp_cur);

	always_comb begin
		case (cmd.mul_op)
			OP_DIFF: begin
				mul_a = MUL_A_W'(delayed) - MUL_A_W'(damp_cur);
				mul_b = {1'b0, dcoef_q};
			end
			OP_GAIN: begin
				mul_a = MUL_A_W'(damp_cur);
				mul_b = {1'b0, gain_q};
			end
			OP_FRAC_HI: begin
				mul_a = {{(MUL_A_W-TAB_W){1'b0}}, d_q};
				mul_b = {{(MUL_B_W-FRAC_HI_W){1'b0}}, frac_q[SPAN_SHIFT-1:FRAC_LO_W]};
			end
			OP_FRAC_LO: begin
				mul_a = {{(MUL_A_W-TAB_W){1'b0}}, d_q};
				mul_b = {{(MUL_B_W-FRAC_LO_W){1'b0}}, frac_q[FRAC_LO_W-1:0]};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// round half up of a Q16 product
	assign prod_sum = prod_q + PROD_HALF;
	assign prod_rnd = prod_sum >>> 16;

	assign damp_sum = 28'(damp_cur) + 28'(prod_rnd);
	assign damp_new = sat25(damp_sum);

	// table position of |x|
	assign x_abs = prod_rnd[PROD_W-1] ? PROD_W'(-prod_rnd) : PROD_W'(prod_rnd);
	assign ax    = x_abs[OUT_W-1:0];
	assign pos   = POS_W'(ax) * POS_W'(TANH_TABLE_SIZE);
	assign idx   = pos[POS_W-1:SPAN_SHIFT];
	assign sat   = (idx >= TI_W'(TANH_TABLE_SIZE));
	assign ti    = sat ? '0 : idx;
	assign t_lo  = TANH_TAB[ti];
	assign t_hi  = TANH_TAB[TI_W'(ti + 1'b1)];

	// interpolation step from the two partial products
	assign isum = ISUM_W'({acc_q, {FRAC_LO_W{1'b0}}}) + ISUM_W'(prod_q) + ISUM_HALF;
	assign ymag = sat_q ? OUT_W'(Q23_ONE)
	                    : OUT_W'(lo_q) + OUT_W'(isum[ISUM_W-1:SPAN_SHIFT]);

	assign w_sum = 28'(smp_q) + 28'(y_q);
	assign w_val = sat25(w_sum);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dlen_q  <= DLEN_RESET;
			dcoef_q <= DAMP_RESET;
			gain_q  <= GAIN_RESET;
			for (int c = 0; c < CHANNELS; c++) begin
				wp_q[c]      <= '0;
				wrapped_q[c] <= 1'b0;
				damp_q[c]    <= '0;
			end
		end else begin
			if (cfg_we) begin
				case (cfg_reg_t'(cfg_index))
					REG_DELAY_LENGTH:        dlen_q  <= cfg_data[DLEN_W-1:0];
					REG_DAMPING_COEFFICIENT: dcoef_q <= cfg_data[COEF_W-1:0];
					REG_FEEDBACK_GAIN:       gain_q  <= cfg_data[COEF_W-1:0];
					default: ;
				endcase
			end
			if (cmd.damp_upd) begin
				damp_q[ch_idx] <= damp_new;
			end
			if (cmd.commit && ch_ok_q) begin
				if (32'(wp_cur) == 32'(BUF_DEPTH - 1)) begin
					wp_q[ch_idx]      <= '0;
					wrapped_q[ch_idx] <= 1'b1;
				end else begin
					wp_q[ch_idx] <= wp_cur + 1'b1;
				end
			end
		end
	end

	// delay memory; an entry reads as zero until its line has been written that far
	always_ff @(posedge clk) begin
		if (cmd.read) begin
			rdata_q <= mem_q[raddr];
			rdv_q   <= wrapped_q[ch_idx] || (rp < wp_cur);
		end
		if (cmd.commit && ch_ok_q) begin
			mem_q[waddr] <= w_val;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			ch_q    <= channel;
			ch_ok_q <= (32'(channel) < 32'(CHANNELS));
			smp_q   <= sample_in;
		end
		if (cmd.mul_en) begin
			if (cmd.mul_op == OP_FRAC_LO) begin
				acc_q <= prod_q;
			end
			prod_q <= mul_a * mul_b;
		end
		if (cmd.tanh_prep) begin
			neg_q  <= prod_rnd[PROD_W-1];
			sat_q  <= sat;
			lo_q   <= t_lo;
			d_q    <= (t_hi > t_lo) ? (t_hi - t_lo) : '0;
			frac_q <= pos[SPAN_SHIFT-1:0];
		end
		if (cmd.interp) begin
			y_q <= neg_q ? -26'(ymag) : 26'(ymag);
		end
		if (cmd.commit) begin
			sample_out_q <= ch_ok_q ? delayed : '0;
		end
	end

endmodule

FILE: sv/damped_comb_resonator.sv
// Top level of the damped comb resonator: controller, datapath and configuration port.
// Depends on dcr_pkg, dcr_ctrl and dcr_datapath.
//
// A request passes from acceptance to its result entering the output register through
// a read of the channel's delay line, then four passes through a single shared
// 26 x 17 bit multiplier (damping difference, feedback gain, and the tanh interpolation
// split into two partial products) with their rounding, table and saturation steps in
// between. A new request is taken in the cycle after the previous result has been placed
// in the output register, even while that result is still stalled, so only one request
// is in flight at a time; a result waiting longer holds the next request in its last step.
// Delay lines read as zero until written, tracked by each channel's write position and a
// wrap flag, so no clearing pass follows reset.
// Configuration is always ready and should be written only while the block is idle.
module damped_comb_resonator (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              channel,
	input  logic signed [dcr_pkg::SMP_W-1:0]  sample_in,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic signed [dcr_pkg::OUT_W-1:0]  sample_out,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [dcr_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [dcr_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import dcr_pkg::*;

	dcr_cmd_t cmd;
	dcr_sts_t sts;
	logic     cfg_we;

	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid && cfg_ready;

	dcr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	dcr_datapath u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.channel    (channel),
		.sample_in  (sample_in),
		.sample_out (sample_out)
	);

endmodule

FILE: sv/dcr_checker.sv
// Port-level checks for the damped comb resonator, bound to damped_comb_resonator.
// Sees only the top level's handshake ports.
module dcr_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall
);

	// one request at a time: an accepted request holds the input side next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input not held after an accepted request");

	// a result appears only as the block finishes a request
	a_result_at_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> ($past(in_stall) && !in_stall))
		else $error("result appeared outside the end of a request");

	// every finished request leaves a result in the output register
	a_finish_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(in_stall) |-> out_valid)
		else $error("request finished without a result");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> out_valid)
		else $error("stalled result dropped");

endmodule

bind damped_comb_resonator dcr_checker u_dcr_checker (.*);
